// File: design/gcsi_pkg.sv
// Shared constants, register codes and width helpers for the colour gradient stop interpolator.
package gcsi_pkg;

  localparam int MAX_STOPS_DEF    = 4;
  localparam int CHANNEL_BITS_DEF = 12;

  localparam int NUM_CH      = 4;
  localparam int POS_W       = 16;
  localparam int DIFF_W      = POS_W + 1;
  localparam int SLOT_W      = 12;
  localparam int WORD_W      = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int COUNT_W     = 3;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STOP_COUNT  = 3'd0,
    REG_STOP_WORD_0 = 3'd1,
    REG_STOP_WORD_1 = 3'd2,
    REG_STOP_WORD_2 = 3'd3,
    REG_STOP_WORD_3 = 3'd4
  } cfg_reg_t;

  // Job layout: base colours, channel deltas, denominator, position offset.
  function automatic int job_width(int cb);
    return 2 * DIFF_W + NUM_CH * (2 * cb + 1);
  endfunction

  // LSB of a channel's 12-bit slot in a stop word; channel 0 is red.
  function automatic int slot_lsb(int ch);
    return WORD_W - POS_W - SLOT_W * (ch + 1);
  endfunction

endpackage

// File: design/gcsi_if.sv
// Valid/ready channel interfaces for lookups, colours and register writes.
interface gcsi_in_if;
  logic                       valid;
  logic                       ready;
  logic [gcsi_pkg::POS_W-1:0] ramp_position;

  modport source (output valid, output ramp_position, input ready);
  modport sink   (input valid, input ramp_position, output ready);
endinterface

interface gcsi_out_if;
  logic                        valid;
  logic                        ready;
  logic [gcsi_pkg::SLOT_W-1:0] red_out;
  logic [gcsi_pkg::SLOT_W-1:0] green_out;
  logic [gcsi_pkg::SLOT_W-1:0] blue_out;
  logic [gcsi_pkg::SLOT_W-1:0] alpha_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, output ready);
endinterface

interface gcsi_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gcsi_pkg::CFG_IDX_W-1:0] index;
  logic [gcsi_pkg::WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/gcsi_front.sv
// Front end: stop registers, nearest/neighbour classification and job formation.
module gcsi_front #(
  parameter int MAX_STOPS    = gcsi_pkg::MAX_STOPS_DEF,
  parameter int CHANNEL_BITS = gcsi_pkg::CHANNEL_BITS_DEF,
  parameter int JOB_W        = gcsi_pkg::job_width(gcsi_pkg::CHANNEL_BITS_DEF)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gcsi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gcsi_pkg::WORD_W-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [gcsi_pkg::POS_W-1:0]       in_pos,
  output logic                             job_valid,
  input  logic                             job_ready,
  output logic [JOB_W-1:0]                 job
);

  localparam int SIDX_W  = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam int DC_W    = CHANNEL_BITS + 1;
  localparam int NCH     = gcsi_pkg::NUM_CH;
  localparam int POS_W   = gcsi_pkg::POS_W;
  localparam int DIFF_W  = gcsi_pkg::DIFF_W;
  localparam int WORD_W  = gcsi_pkg::WORD_W;
  localparam int COUNT_W = gcsi_pkg::COUNT_W;
  localparam int IDX_W   = gcsi_pkg::CFG_IDX_W;
  localparam int DC_OFS  = NCH * CHANNEL_BITS;
  localparam int DEN_OFS = DC_OFS + NCH * DC_W;
  localparam int DX_OFS  = DEN_OFS + DIFF_W;

  logic [WORD_W-1:0]  stop_r [MAX_STOPS];
  logic [COUNT_W-1:0] count_r;
  logic [IDX_W-1:0]   wr_slot;

  logic                     job_vld_r;
  logic [JOB_W-1:0]         job_r;
  logic [JOB_W-1:0]         job_nxt;

  logic [COUNT_W-1:0]       n_eff;
  logic signed [DIFF_W-1:0] t;
  logic signed [DIFF_W-1:0] t_abs;
  logic [POS_W-1:0]         gap;
  logic [POS_W-1:0]         best;
  logic [SIDX_W-1:0]        near;
  logic [SIDX_W-1:0]        other;
  logic [SIDX_W-1:0]        lo;
  logic [SIDX_W-1:0]        hi;
  logic [POS_W-1:0]         x0;
  logic [POS_W-1:0]         x1;
  logic [CHANNEL_BITS-1:0]  c_lo   [NCH];
  logic [CHANNEL_BITS-1:0]  c_hi   [NCH];
  logic [CHANNEL_BITS-1:0]  c_near [NCH];
  logic                     pass;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] den;
  logic signed [DC_W-1:0]   dc;

  assign cfg_ready = 1'b1;
  assign wr_slot   = cfg_index - IDX_W'(gcsi_pkg::REG_STOP_WORD_0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_W'(1);
      for (int k = 0; k < MAX_STOPS; k++) begin
        stop_r[k] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index) inside
        gcsi_pkg::REG_STOP_COUNT: begin
          count_r <= cfg_data[COUNT_W-1:0];
        end
        gcsi_pkg::REG_STOP_WORD_0, gcsi_pkg::REG_STOP_WORD_1,
        gcsi_pkg::REG_STOP_WORD_2, gcsi_pkg::REG_STOP_WORD_3: begin
          for (int k = 0; k < MAX_STOPS; k++) begin
            if (wr_slot == IDX_W'(k)) begin
              stop_r[k] <= cfg_data;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Nearest stop (first wins ties) and the neighbour on the side of the position
  always_comb begin
    if (count_r == '0) begin
      n_eff = COUNT_W'(1);
    end else if (count_r > COUNT_W'(MAX_STOPS)) begin
      n_eff = COUNT_W'(MAX_STOPS);
    end else begin
      n_eff = count_r;
    end

    near  = '0;
    other = '0;
    best  = '0;
    t     = '0;
    t_abs = '0;
    gap   = '0;
    for (int i = 0; i < MAX_STOPS; i++) begin
      t     = $signed({1'b0, stop_r[i][WORD_W-1 -: POS_W]}) - $signed({1'b0, in_pos});
      t_abs = t[DIFF_W-1] ? -t : t;
      gap   = t_abs[POS_W-1:0];
      if ((COUNT_W'(i) < n_eff) && ((i == 0) || (gap < best))) begin
        best = gap;
        near = SIDX_W'(i);
        if (t[DIFF_W-1]) begin
          other = (COUNT_W'(i + 1) < n_eff) ? SIDX_W'(i + 1) : SIDX_W'(n_eff - COUNT_W'(1));
        end else if (t != '0) begin
          other = (i > 0) ? SIDX_W'(i - 1) : '0;
        end else begin
          other = SIDX_W'(i);
        end
      end
    end

    lo = (near < other) ? near : other;
    hi = (near < other) ? other : near;

    x0 = '0;
    x1 = '0;
    for (int c = 0; c < NCH; c++) begin
      c_lo[c]   = '0;
      c_hi[c]   = '0;
      c_near[c] = '0;
    end
    for (int i = 0; i < MAX_STOPS; i++) begin
      if (lo == SIDX_W'(i)) begin
        x0 = stop_r[i][WORD_W-1 -: POS_W];
        for (int c = 0; c < NCH; c++) begin
          c_lo[c] = stop_r[i][gcsi_pkg::slot_lsb(c) +: CHANNEL_BITS];
        end
      end
      if (hi == SIDX_W'(i)) begin
        x1 = stop_r[i][WORD_W-1 -: POS_W];
        for (int c = 0; c < NCH; c++) begin
          c_hi[c] = stop_r[i][gcsi_pkg::slot_lsb(c) +: CHANNEL_BITS];
        end
      end
      if (near == SIDX_W'(i)) begin
        for (int c = 0; c < NCH; c++) begin
          c_near[c] = stop_r[i][gcsi_pkg::slot_lsb(c) +: CHANNEL_BITS];
        end
      end
    end

    // Pass-through jobs carry a zero offset, so the back end returns the base
    pass = (near == other) || (x1 == x0);
    dx   = pass ? '0 : ($signed({1'b0, in_pos}) - $signed({1'b0, x0}));
    den  = pass ? DIFF_W'(1) : ($signed({1'b0, x1}) - $signed({1'b0, x0}));

    job_nxt = '0;
    dc      = '0;
    for (int c = 0; c < NCH; c++) begin
      dc = $signed({1'b0, c_hi[c]}) - $signed({1'b0, c_lo[c]});
      job_nxt[c * CHANNEL_BITS +: CHANNEL_BITS] = pass ? c_near[c] : c_lo[c];
      job_nxt[DC_OFS + c * DC_W +: DC_W]         = dc;
    end
    job_nxt[DEN_OFS +: DIFF_W] = den;
    job_nxt[DX_OFS +: DIFF_W]  = dx;
  end

  assign in_ready  = !job_vld_r || job_ready;
  assign job_valid = job_vld_r;
  assign job       = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
    end else if (in_ready) begin
      job_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      job_r <= job_nxt;
    end
  end

endmodule

// File: design/gcsi_queue.sv
// Small FIFO that decouples the classification front end from the arithmetic back end.
module gcsi_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = gcsi_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/gcsi_back.sv
// Back end: offset-times-delta multiply, pipelined signed divide and clamped colour output.
module gcsi_back #(
  parameter int CHANNEL_BITS = gcsi_pkg::CHANNEL_BITS_DEF,
  parameter int JOB_W        = gcsi_pkg::job_width(gcsi_pkg::CHANNEL_BITS_DEF)
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            job_valid,
  output logic                                            job_ready,
  input  logic [JOB_W-1:0]                                job,
  output logic                                            out_valid,
  input  logic                                            out_ready,
  output logic [gcsi_pkg::NUM_CH-1:0][gcsi_pkg::SLOT_W-1:0] out_colour
);

  localparam int NCH     = gcsi_pkg::NUM_CH;
  localparam int POS_W   = gcsi_pkg::POS_W;
  localparam int DIFF_W  = gcsi_pkg::DIFF_W;
  localparam int SLOT_W  = gcsi_pkg::SLOT_W;
  localparam int DC_W    = CHANNEL_BITS + 1;
  localparam int PROD_W  = DIFF_W + DC_W;
  localparam int NUM_W   = POS_W + CHANNEL_BITS;
  localparam int DEN_W   = POS_W;
  localparam int V_W     = NUM_W + 2;
  localparam int DC_OFS  = NCH * CHANNEL_BITS;
  localparam int DEN_OFS = DC_OFS + NCH * DC_W;
  localparam int DX_OFS  = DEN_OFS + DIFF_W;
  localparam logic signed [V_W-1:0] CH_MAX = V_W'((1 << CHANNEL_BITS) - 1);

  logic adv;

  // multiply stage
  logic                          mul_vld_r;
  logic signed [PROD_W-1:0]      mul_prod_r [NCH];
  logic signed [DIFF_W-1:0]      mul_den_r;
  logic [CHANNEL_BITS-1:0]       mul_base_r [NCH];
  logic signed [PROD_W-1:0]      mul_prod_nxt [NCH];
  logic signed [PROD_W-1:0]      j_dx_ext;
  logic signed [PROD_W-1:0]      j_dc_ext [NCH];

  // divider stages, one quotient bit each
  logic                          dv_vld_r  [NUM_W];
  logic [DEN_W-1:0]              dv_rem_r  [NUM_W][NCH];
  logic [NUM_W-1:0]              dv_acc_r  [NUM_W][NCH];
  logic                          dv_neg_r  [NUM_W][NCH];
  logic [DEN_W-1:0]              dv_dmag_r [NUM_W];
  logic [CHANNEL_BITS-1:0]       dv_base_r [NUM_W][NCH];

  logic [DEN_W-1:0]              st_rem  [NUM_W][NCH];
  logic [NUM_W-1:0]              st_acc  [NUM_W][NCH];
  logic                          st_neg  [NUM_W][NCH];
  logic [DEN_W-1:0]              st_dmag [NUM_W];
  logic [CHANNEL_BITS-1:0]       st_base [NUM_W][NCH];
  logic [DEN_W:0]                rsh     [NUM_W][NCH];
  logic                          ge      [NUM_W][NCH];
  logic [DEN_W-1:0]              rem_nxt [NUM_W][NCH];
  logic [NUM_W-1:0]              acc_nxt [NUM_W][NCH];
  logic [PROD_W-1:0]             prod_abs [NCH];
  logic [DIFF_W-1:0]             den_abs;

  // output stage
  logic                          out_vld_r;
  logic [CHANNEL_BITS-1:0]       out_ch_r   [NCH];
  logic [CHANNEL_BITS-1:0]       out_ch_nxt [NCH];
  logic signed [V_W-1:0]         q_s  [NCH];
  logic signed [V_W-1:0]         v_s  [NCH];

  assign adv       = !out_vld_r || out_ready;
  assign job_ready = adv;
  assign out_valid = out_vld_r;

  always_comb begin
    j_dx_ext = PROD_W'($signed(job[DX_OFS +: DIFF_W]));
    for (int c = 0; c < NCH; c++) begin
      j_dc_ext[c]     = PROD_W'($signed(job[DC_OFS + c * DC_W +: DC_W]));
      mul_prod_nxt[c] = j_dx_ext * j_dc_ext[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else if (adv) begin
      mul_vld_r <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mul_den_r <= $signed(job[DEN_OFS +: DIFF_W]);
      for (int c = 0; c < NCH; c++) begin
        mul_prod_r[c] <= mul_prod_nxt[c];
        mul_base_r[c] <= job[c * CHANNEL_BITS +: CHANNEL_BITS];
      end
    end
  end

  // Restoring division on magnitudes; quotient bits shift into the low end
  always_comb begin
    den_abs = mul_den_r[DIFF_W-1] ? DIFF_W'(-mul_den_r) : DIFF_W'(mul_den_r);
    for (int c = 0; c < NCH; c++) begin
      prod_abs[c] = mul_prod_r[c][PROD_W-1] ? PROD_W'(-mul_prod_r[c]) : PROD_W'(mul_prod_r[c]);
    end
    for (int s = 0; s < NUM_W; s++) begin
      if (s == 0) begin
        st_dmag[s] = den_abs[DEN_W-1:0];
      end else begin
        st_dmag[s] = dv_dmag_r[s-1];
      end
      for (int c = 0; c < NCH; c++) begin
        if (s == 0) begin
          st_rem[s][c]  = '0;
          st_acc[s][c]  = prod_abs[c][NUM_W-1:0];
          st_neg[s][c]  = mul_prod_r[c][PROD_W-1] ^ mul_den_r[DIFF_W-1];
          st_base[s][c] = mul_base_r[c];
        end else begin
          st_rem[s][c]  = dv_rem_r[s-1][c];
          st_acc[s][c]  = dv_acc_r[s-1][c];
          st_neg[s][c]  = dv_neg_r[s-1][c];
          st_base[s][c] = dv_base_r[s-1][c];
        end
        rsh[s][c]     = {st_rem[s][c], st_acc[s][c][NUM_W-1]};
        ge[s][c]      = (rsh[s][c] >= {1'b0, st_dmag[s]});
        rem_nxt[s][c] = ge[s][c] ? DEN_W'(rsh[s][c] - {1'b0, st_dmag[s]})
                                 : rsh[s][c][DEN_W-1:0];
        acc_nxt[s][c] = {st_acc[s][c][NUM_W-2:0], ge[s][c]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_W; s++) begin
        dv_vld_r[s] <= 1'b0;
      end
    end else if (adv) begin
      dv_vld_r[0] <= mul_vld_r;
      for (int s = 1; s < NUM_W; s++) begin
        dv_vld_r[s] <= dv_vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < NUM_W; s++) begin
        dv_dmag_r[s] <= st_dmag[s];
        for (int c = 0; c < NCH; c++) begin
          dv_rem_r[s][c]  <= rem_nxt[s][c];
          dv_acc_r[s][c]  <= acc_nxt[s][c];
          dv_neg_r[s][c]  <= st_neg[s][c];
          dv_base_r[s][c] <= st_base[s][c];
        end
      end
    end
  end

  // Signed quotient added to the base colour, then clamped to the channel range
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      q_s[c] = $signed({2'b00, dv_acc_r[NUM_W-1][c]});
      if (dv_neg_r[NUM_W-1][c]) begin
        q_s[c] = -q_s[c];
      end
      v_s[c] = $signed({{(V_W - CHANNEL_BITS){1'b0}}, dv_base_r[NUM_W-1][c]}) + q_s[c];
      if (v_s[c] < 0) begin
        out_ch_nxt[c] = '0;
      end else if (v_s[c] > CH_MAX) begin
        out_ch_nxt[c] = CH_MAX[CHANNEL_BITS-1:0];
      end else begin
        out_ch_nxt[c] = v_s[c][CHANNEL_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dv_vld_r[NUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NCH; c++) begin
        out_ch_r[c] <= out_ch_nxt[c];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      out_colour[c] = SLOT_W'(out_ch_r[c]);
    end
  end

endmodule

// File: design/colour_gradient_stop_interpolator.sv
// Top level of the colour gradient stop interpolator: front end, job queue and back end.
//
// Each in_if transaction carries a Q0.16 ramp position; each out_if transaction returns
// one RGBA colour (12-bit channels), in the order the positions were taken.
// cfg_if writes the stop count (index 0) and stop words 0..3 (indexes 1..4); it is always
// ready; the user must write it only while no lookup is in flight, which the block does not check.
// Throughput: one lookup per cycle while out_if is ready.
// On its way to the out_if port, a position passes the front register, the job queue,
// the multiply stage, the one-bit-per-stage divider and the output register.
// The front end classifies a position combinationally, registers the job and hands it to a
// two-entry queue; the back end pulls from it only when its pipeline can move.
// When the receiver stalls, the whole back end holds, the queue fills, and in_if.ready
// drops once the front register cannot drain.
// Reset (rst_n low, synchronous) empties every stage and the queue, sets the stop
// count to one and clears all stop words.
module colour_gradient_stop_interpolator #(
  parameter int MAX_STOPS    = gcsi_pkg::MAX_STOPS_DEF,
  parameter int CHANNEL_BITS = gcsi_pkg::CHANNEL_BITS_DEF
) (
  input logic              clk,
  input logic              rst_n,
  gcsi_in_if.sink          in_if,
  gcsi_out_if.source       out_if,
  gcsi_cfg_if.sink         cfg_if
);

  localparam int JOB_W = gcsi_pkg::job_width(CHANNEL_BITS);

  logic                                               fr_valid;
  logic                                               fr_ready;
  logic [JOB_W-1:0]                                   fr_job;
  logic                                               bk_valid;
  logic                                               bk_ready;
  logic [JOB_W-1:0]                                   bk_job;
  logic [gcsi_pkg::NUM_CH-1:0][gcsi_pkg::SLOT_W-1:0]  colour;

  gcsi_front #(
    .MAX_STOPS    (MAX_STOPS),
    .CHANNEL_BITS (CHANNEL_BITS),
    .JOB_W        (JOB_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_if.valid),
    .cfg_ready (cfg_if.ready),
    .cfg_index (cfg_if.index),
    .cfg_data  (cfg_if.data),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_pos    (in_if.ramp_position),
    .job_valid (fr_valid),
    .job_ready (fr_ready),
    .job       (fr_job)
  );

  gcsi_queue #(
    .WIDTH (JOB_W),
    .DEPTH (gcsi_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_job),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_data   (bk_job)
  );

  gcsi_back #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .JOB_W        (JOB_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (bk_valid),
    .job_ready  (bk_ready),
    .job        (bk_job),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_colour (colour)
  );

  assign out_if.red_out   = colour[0];
  assign out_if.green_out = colour[1];
  assign out_if.blue_out  = colour[2];
  assign out_if.alpha_out = colour[3];

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the colour gradient stop interpolator: directed and random lookups.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gcsi_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_LIMIT  = 100;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 200;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = CHANNEL_BITS_DEF + 19 + 10;

  typedef struct packed {
    logic [SLOT_W-1:0] red;
    logic [SLOT_W-1:0] green;
    logic [SLOT_W-1:0] blue;
    logic [SLOT_W-1:0] alpha;
  } rgba_t;

  // Holds its own copy of the stop registers and the colours still owed by the block.
  class colour_ramp_scoreboard;
    logic [COUNT_W-1:0] count;
    logic [WORD_W-1:0]  words [MAX_STOPS_DEF];
    rgba_t              colour_q [$];
    int                 errors;
    int                 checked;
    int                 noted;

    function new();
      count = 3'd1;
      foreach (words[k]) words[k] = '0;
      errors  = 0;
      checked = 0;
      noted   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
      if (idx == REG_STOP_COUNT)
        count = value[COUNT_W-1:0];
      else if (idx >= REG_STOP_WORD_0 && idx <= REG_STOP_WORD_3)
        words[idx - REG_STOP_WORD_0] = value;
    endfunction

    function longint stop_pos(int k);
      return longint'(words[k][WORD_W-1 -: POS_W]);
    endfunction

    function longint stop_chan(int k, int c);
      return longint'((words[k] >> (36 - SLOT_W * c)) & 64'hFFF);
    endfunction

    function rgba_t ramp_colour(logic [POS_W-1:0] pos);
      int          n, nearest, partner, lo, hi;
      longint      x, t, d, best, x0, den, c0, v;
      logic [SLOT_W-1:0] res [NUM_CH];
      bit          found;
      n = int'(count);
      if (n == 0) n = 1;
      if (n > MAX_STOPS_DEF) n = MAX_STOPS_DEF;
      x = longint'(pos);
      found = 0;
      best = 0;
      nearest = 0;
      partner = 0;
      for (int i = 0; i < n; i++) begin
        t = stop_pos(i) - x;
        d = (t < 0) ? -t : t;
        // strict compare: lowest index keeps a tie
        if (!found || d < best) begin
          found = 1;
          best = d;
          nearest = i;
          if (t < 0)
            partner = (i + 1 < n) ? i + 1 : n - 1;
          else if (t > 0)
            partner = (i > 0) ? i - 1 : 0;
          else
            partner = i;
        end
      end
      lo = (nearest < partner) ? nearest : partner;
      hi = (nearest < partner) ? partner : nearest;
      for (int c = 0; c < NUM_CH; c++) begin
        if (nearest == partner || stop_pos(hi) == stop_pos(lo)) begin
          v = stop_chan(nearest, c);
        end else begin
          x0 = stop_pos(lo);
          den = stop_pos(hi) - x0;
          c0 = stop_chan(lo, c);
          v = c0 + ((x - x0) * (stop_chan(hi, c) - c0)) / den;
          if (v < 0) v = 0;
          if (v > 4095) v = 4095;
        end
        res[c] = v[SLOT_W-1:0];
      end
      return '{res[0], res[1], res[2], res[3]};
    endfunction

    function void note_lookup(logic [POS_W-1:0] pos);
      colour_q.insert(colour_q.size(), ramp_colour(pos));
      noted++;
    endfunction

    function int pending();
      return colour_q.size();
    endfunction

    task report(string msg);
      errors++;
      // keep the log short when the block is badly broken
      if (errors <= PRINT_LIMIT) $display("MISMATCH: %s", msg);
    endtask

    task check_field(string name, logic [SLOT_W-1:0] got, logic [SLOT_W-1:0] want);
      if (got !== want)
        report($sformatf("colour %0d %s: got %h, expected %h", checked, name, got, want));
    endtask

    task check_colour(rgba_t got);
      rgba_t want;
      if (colour_q.size() == 0) begin
        report($sformatf("colour %h%h%h%h arrived with no lookup pending",
                         got.red, got.green, got.blue, got.alpha));
        return;
      end
      want = colour_q.pop_front();
      check_field("red", got.red, want.red);
      check_field("green", got.green, want.green);
      check_field("blue", got.blue, want.blue);
      check_field("alpha", got.alpha, want.alpha);
      checked++;
    endtask
  endclass

  logic clk;
  logic rst_n;

  gcsi_in_if  in_if ();
  gcsi_out_if out_if ();
  gcsi_cfg_if cfg_if ();

  colour_gradient_stop_interpolator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  colour_ramp_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int settings_loaded;
  int cycle_count;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] stop_word(logic [POS_W-1:0] p, logic [SLOT_W-1:0] r,
                                                  logic [SLOT_W-1:0] g, logic [SLOT_W-1:0] b,
                                                  logic [SLOT_W-1:0] a);
    return {p, r, g, b, a};
  endfunction

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_reg(idx, value);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task write_ramp(logic [COUNT_W-1:0] cnt, logic [WORD_W-1:0] w0, logic [WORD_W-1:0] w1,
                  logic [WORD_W-1:0] w2, logic [WORD_W-1:0] w3);
    write_reg(REG_STOP_COUNT, WORD_W'(cnt));
    write_reg(REG_STOP_WORD_0, w0);
    write_reg(REG_STOP_WORD_1, w1);
    write_reg(REG_STOP_WORD_2, w2);
    write_reg(REG_STOP_WORD_3, w3);
    settings_loaded++;
  endtask

  task send_lookup(logic [POS_W-1:0] pos);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid         <= 1'b1;
    in_if.ramp_position <= pos;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_lookup(pos);
  endtask

  task drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [SLOT_W-1:0] pick_channel();
    int sel;
    sel = $urandom_range(7);
    if (sel == 0) return '0;
    if (sel == 1) return 12'hFFF;
    return 12'($urandom_range(4095));
  endfunction

  task load_random_ramp();
    logic [POS_W-1:0]  pq [$];
    logic [WORD_W-1:0] w [MAX_STOPS_DEF];
    int                kind, sel;
    logic [COUNT_W-1:0] cnt;
    kind = $urandom_range(9);
    pq = {};
    for (int k = 0; k < MAX_STOPS_DEF; k++) pq.insert(pq.size(), 16'($urandom));
    if (kind < 7) begin
      pq.sort();
      if (kind == 5) pq[2] = pq[1];  // coincident stops
      if ($urandom_range(3) == 0) pq[0] = 16'h0000;
      if ($urandom_range(3) == 0) pq[MAX_STOPS_DEF-1] = 16'hFFFF;
    end
    for (int k = 0; k < MAX_STOPS_DEF; k++) begin
      if (kind == 9)
        w[k] = {$urandom, $urandom};
      else
        w[k] = stop_word(pq[k], pick_channel(), pick_channel(), pick_channel(), pick_channel());
    end
    sel = $urandom_range(15);
    cnt = (sel < 8) ? COUNT_W'(sel % 4 + 1) : COUNT_W'(sel - 8);
    write_ramp(cnt, w[0], w[1], w[2], w[3]);
    if ($urandom_range(3) == 0)
      write_reg(CFG_IDX_W'(REG_STOP_WORD_3 + 1 + $urandom_range(2)), {$urandom, $urandom});
  endtask

  function automatic logic [POS_W-1:0] pick_position();
    int               sel;
    logic [POS_W-1:0] anchor;
    sel = $urandom_range(9);
    anchor = sb.words[$urandom_range(MAX_STOPS_DEF-1)][WORD_W-1 -: POS_W];
    if (sel < 4) return 16'($urandom);
    if (sel < 6) return anchor;
    if (sel < 9) return anchor + 16'($urandom_range(64)) - 16'd32;
    return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
  endfunction

  // Receiver: checks every colour transaction and throttles out_if.ready.
  initial begin
    int seen, hold_left;
    bit held;
    seen = 0;
    hold_left = 0;
    held = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        sb.check_colour('{out_if.red_out, out_if.green_out, out_if.blue_out, out_if.alpha_out});
        seen++;
      end
      // one long hold-off so the queue fills and in_if.ready drops
      if (!held && seen == HOLD_AT) begin
        held = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    stall_cycles = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
      if (in_if.valid === 1'b1 && in_if.ready === 1'b0) stall_cycles++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    sb = new();
    settings_loaded = 0;
    send_idle_pct = 14;
    recv_idle_pct = 58;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.ramp_position = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: single stop at zero, black
    send_lookup(16'h8000);
    drain();

    // sorted ramp, both ends, exact hits, first-wins tie, clamp at top
    write_ramp(3'd4, stop_word(16'h0000, 12'h000, 12'hFFF, 12'h000, 12'hFFF),
               stop_word(16'h4000, 12'hFFF, 12'h000, 12'h800, 12'hFFF),
               stop_word(16'hC000, 12'h064, 12'hBB8, 12'hFFF, 12'h000),
               stop_word(16'hFFF0, 12'hFFF, 12'hFFF, 12'h000, 12'h001));
    send_lookup(16'h0000);
    send_lookup(16'hFFFF);
    send_lookup(16'h4000);
    send_lookup(16'h2000);
    send_lookup(16'h8000);
    send_lookup(16'hE000);
    send_lookup(16'h0001);
    drain();

    // zero count acts as one stop; writes past the register list are dropped
    write_reg(REG_STOP_COUNT, '0);
    for (int k = REG_STOP_WORD_3 + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), {$urandom, $urandom});
    send_lookup(16'h1234);
    send_lookup(16'hFFFF);
    drain();

    // count above the stop limit, coincident pairs, clamp below the first stop
    write_ramp(3'd7, stop_word(16'h1000, 12'h123, 12'h456, 12'h789, 12'hABC),
               stop_word(16'h1000, 12'hFFF, 12'h000, 12'hFFF, 12'h000),
               stop_word(16'h9000, 12'h000, 12'hFFF, 12'h000, 12'hFFF),
               stop_word(16'h9000, 12'h555, 12'hAAA, 12'h555, 12'hAAA));
    send_lookup(16'h0800);
    send_lookup(16'h1000);
    send_lookup(16'h1800);
    send_lookup(16'hF000);
    drain();

    // unsorted stops: signed slope and channel saturation
    write_ramp(3'd3, stop_word(16'hF000, 12'h000, 12'h000, 12'h000, 12'h000),
               stop_word(16'h1000, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF),
               stop_word(16'h8000, 12'hFFF, 12'h000, 12'h7D0, 12'h00A),
               stop_word(16'h0000, 12'h000, 12'h000, 12'h000, 12'h000));
    send_lookup(16'h0000);
    send_lookup(16'hC000);
    send_lookup(16'h9000);
    send_lookup(16'h6000);
    send_lookup(16'h5000);
    send_lookup(16'hFFFF);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 4) begin
        send_idle_pct = 14;
        recv_idle_pct = 58;
      end else if (ph < 7) begin
        send_idle_pct = 58;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_random_ramp();
      for (int i = 0; i < PHASE_ITEMS; i++) send_lookup(pick_position());
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d lookups over %0d stop settings, %0d colours compared.",
             sb.noted, settings_loaded, sb.checked);
    $display("Input back-pressure held an offered position for %0d cycles; %0d mismatches.",
             stall_cycles, sb.errors);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
